@@ hdl/qs_pkg.sv @@
package qs_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int WBITS        = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 61;

   localparam logic [14:0] THR_RESET = 15'd16;
   localparam logic [14:0] T_ONE     = 15'(1 << FRAC_BITS);
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh26DD3B6A;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   // Stage positions in the back-end pipeline.
   localparam int S_B0  = 0;
   localparam int S_B1  = 1;
   localparam int S_B2  = 2;
   localparam int S_SQ0 = 3;
   localparam int S_T   = S_SQ0 + SQRT_STEPS;
   localparam int S_AT0 = S_T + 1;
   localparam int S_H   = S_AT0 + CORDIC_STEPS;
   localparam int S_M   = S_H + 1;
   localparam int S_SN0 = S_M + 1;
   localparam int S_SC  = S_SN0 + CORDIC_STEPS;
   localparam int S_DV0 = S_SC + 1;
   localparam int S_P   = S_DV0 + DIV_STEPS;
   localparam int S_Q   = S_P + 1;
   localparam int N_STAGES = S_Q + 1;

   typedef enum logic [1:0] {
      PATH_KEEP   = 2'd0,
      PATH_LINEAR = 2'd1,
      PATH_SLERP  = 2'd2
   } path_type;

   typedef logic signed [16:0] qc_type;
   typedef logic signed [15:0] comp_type;

   typedef struct packed {
      qc_type   [3:0] q;
      comp_type [3:0] r;
      logic     [14:0] t;
      logic           keep;
      logic     [29:0] c;
   } ctx_type;

   typedef struct packed {
      ctx_type        ctx;
      comp_type [3:0] lin;
      logic           lin_sel;
      logic    [30:0] s;
   } side_type;

   function automatic comp_type sat16(input logic signed [47:0] v);
      comp_type res;
      if (v > 48'sd32767) begin
         res = 16'sh7FFF;
      end else if (v < -48'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

endpackage

@@ hdl/qs_front.sv @@
module qs_front #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_q_w,
   input  logic signed [15:0] req_q_x,
   input  logic signed [15:0] req_q_y,
   input  logic signed [15:0] req_q_z,
   input  logic signed [15:0] req_r_w,
   input  logic signed [15:0] req_r_x,
   input  logic signed [15:0] req_r_y,
   input  logic signed [15:0] req_r_z,
   input  logic [14:0] req_blend,
   input  logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count,
   output logic push_valid,
   output qs_pkg::ctx_type push_ctx
);
   import qs_pkg::*;

   localparam int CW = $clog2(FIFO_DEPTH + 3);

   logic f1_valid_ff, f2_valid_ff;
   comp_type [3:0] f1_q_ff, f1_r_ff, f2_q_ff, f2_r_ff;
   logic [14:0] f1_t_ff, f2_t_ff;
   logic signed [31:0] f2_prod_ff [4];
   logic [CW-1:0] occupancy;
   logic signed [33:0] dot, dot_abs;
   logic neg;

   // Items in flight in the front plus those queued must fit in the queue.
   assign occupancy = CW'(fifo_count) + CW'(f1_valid_ff) + CW'(f2_valid_ff);
   assign req_ready = occupancy < CW'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= req_valid && req_ready;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_q_ff <= {req_q_z, req_q_y, req_q_x, req_q_w};
      f1_r_ff <= {req_r_z, req_r_y, req_r_x, req_r_w};
      f1_t_ff <= (req_blend > T_ONE) ? T_ONE : req_blend;
      f2_q_ff <= f1_q_ff;
      f2_r_ff <= f1_r_ff;
      f2_t_ff <= f1_t_ff;
      for (int i = 0; i < 4; i++) begin
         f2_prod_ff[i] <= 32'($signed(f1_q_ff[i])) * 32'($signed(f1_r_ff[i]));
      end
   end

   always_comb begin
      dot = '0;
      for (int i = 0; i < 4; i++) begin
         dot = dot + 34'(f2_prod_ff[i]);
      end
      neg = dot[33];
      dot_abs = neg ? -dot : dot;
      for (int i = 0; i < 4; i++) begin
         push_ctx.q[i] = neg ? -17'($signed(f2_q_ff[i])) : 17'($signed(f2_q_ff[i]));
      end
      push_ctx.r    = f2_r_ff;
      push_ctx.t    = f2_t_ff;
      push_ctx.keep = dot_abs >= (34'sd1 <<< (2 * FRAC_BITS));
      push_ctx.c    = 30'(dot_abs << (WBITS - 2 * FRAC_BITS));
   end

   assign push_valid = f2_valid_ff;

endmodule

@@ hdl/qs_fifo.sv @@
module qs_fifo #(
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  qs_pkg::ctx_type push_ctx,
   input  logic pop,
   output logic head_valid,
   output qs_pkg::ctx_type head_ctx,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import qs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ctx_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push_valid) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_ctx;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_ctx   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

@@ hdl/qs_back.sv @@
module qs_back (
   input  logic clock,
   input  logic reset,
   input  logic [14:0] thr,
   input  logic head_valid,
   input  qs_pkg::ctx_type head_ctx,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_out_w,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic [1:0] rsp_path
);
   import qs_pkg::*;

   logic adv;
   logic [N_STAGES-1:0] valid_ff;
   side_type side_ff [N_STAGES];
   side_type side_in [N_STAGES];

   logic [59:0] cc_ff;
   logic signed [32:0] lsum_ff [4];
   logic [60:0] nrad_ff;
   logic [61:0] sq_n_ff [SQRT_STEPS];
   logic [61:0] sq_r_ff [SQRT_STEPS];
   logic signed [33:0] at_x_ff [CORDIC_STEPS];
   logic signed [33:0] at_y_ff [CORDIC_STEPS];
   logic signed [32:0] at_z_ff [CORDIC_STEPS];
   logic [31:0] h_ff;
   logic [31:0] ang_ff [2];
   logic signed [33:0] sn_x_ff [2][CORDIC_STEPS];
   logic signed [33:0] sn_y_ff [2][CORDIC_STEPS];
   logic signed [33:0] sn_z_ff [2][CORDIC_STEPS];
   logic [30:0] sv_ff [2];
   logic [30:0] dv_rem_ff [2][DIV_STEPS];
   logic [60:0] dv_quo_ff [2][DIV_STEPS];
   logic [30:0] dv_num_ff [2][DIV_STEPS];
   logic signed [48:0] pa_lo_ff [4];
   logic signed [48:0] pb_lo_ff [4];
   logic signed [47:0] pa_hi_ff [4];
   logic signed [47:0] pb_hi_ff [4];
   logic signed [63:0] acc_ff [4];

   logic rsp_valid_ff;
   comp_type [3:0] rsp_out_ff;
   path_type rsp_path_ff;

   // The whole back end moves as one when the output register can take a result.
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[N_STAGES-2:0], head_valid};
         rsp_valid_ff <= valid_ff[N_STAGES-1];
      end
   end

   // Per-item context, filled in as results become known.
   always_comb begin
      logic [14:0] omt;
      logic signed [47:0] lr;
      logic [30:0] s_val;
      omt = 15'(T_ONE - side_ff[S_B1].ctx.t);
      side_in[0].ctx     = head_ctx;
      side_in[0].lin     = '0;
      side_in[0].lin_sel = 1'b0;
      side_in[0].s       = '0;
      for (int k = 1; k < N_STAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
      for (int i = 0; i < 4; i++) begin
         lr = (48'(lsum_ff[i]) + 48'sd8192) >>> FRAC_BITS;
         side_in[S_B2].lin[i] = sat16(lr);
      end
      s_val = sq_r_ff[SQRT_STEPS-1][30:0];
      side_in[S_T].s       = s_val;
      side_in[S_T].lin_sel = s_val < (31'(thr) << (WBITS - FRAC_BITS));
      if (omt == '0) begin
         side_in[S_T].s = s_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N_STAGES; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // Square of the cosine, one minus that square, and the linear blend sums.
   always_ff @(posedge clock) begin
      logic [14:0] omt1;
      if (adv) begin
         omt1 = 15'(T_ONE - side_ff[S_B0].ctx.t);
         cc_ff <= 60'(side_ff[S_B0].ctx.c) * 60'(side_ff[S_B0].ctx.c);
         for (int i = 0; i < 4; i++) begin
            lsum_ff[i] <= 33'($signed({1'b0, omt1})) * 33'($signed(side_ff[S_B0].ctx.q[i]))
                        + 33'($signed({1'b0, side_ff[S_B0].ctx.t}))
                        * 33'($signed(side_ff[S_B0].ctx.r[i]));
         end
         nrad_ff <= (61'd1 << (2 * WBITS)) - 61'(cc_ff);
      end
   end

   // Integer square root, one result bit per stage.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [61:0] n_prev, r_prev, bitv, sum, n_in, r_in;
      always_comb begin
         n_prev = (k == 0) ? 62'(nrad_ff) : sq_n_ff[(k == 0) ? 0 : k-1];
         r_prev = (k == 0) ? '0 : sq_r_ff[(k == 0) ? 0 : k-1];
         bitv   = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
         sum    = r_prev + bitv;
         if (n_prev >= sum) begin
            n_in = n_prev - sum;
            r_in = (r_prev >> 1) + bitv;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_n_ff[k] <= n_in;
            sq_r_ff[k] <= r_in;
         end
      end
   end

   // Vectoring CORDIC for the half angle.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
      logic signed [33:0] x_prev, y_prev, x_in, y_in;
      logic signed [32:0] z_prev, z_in, step;
      always_comb begin
         if (i == 0) begin
            x_prev = $signed({4'b0, side_ff[S_T].ctx.c});
            y_prev = $signed({3'b0, side_ff[S_T].s});
            z_prev = '0;
         end else begin
            x_prev = at_x_ff[(i == 0) ? 0 : i-1];
            y_prev = at_y_ff[(i == 0) ? 0 : i-1];
            z_prev = at_z_ff[(i == 0) ? 0 : i-1];
         end
         step = $signed({1'b0, ATAN_TAB[i]});
         if (!y_prev[33]) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + step;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - step;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            at_x_ff[i] <= x_in;
            at_y_ff[i] <= y_in;
            at_z_ff[i] <= z_in;
         end
      end
   end

   // Clamp the angle, then split it by the blend factor.
   always_ff @(posedge clock) begin
      logic [46:0] pa, pb;
      logic [14:0] omt2;
      if (adv) begin
         h_ff <= at_z_ff[CORDIC_STEPS-1][32] ? '0 : at_z_ff[CORDIC_STEPS-1][31:0];
         omt2 = 15'(T_ONE - side_ff[S_H].ctx.t);
         pa = 47'(omt2) * 47'(h_ff);
         pb = 47'(side_ff[S_H].ctx.t) * 47'(h_ff);
         ang_ff[0] <= 32'(pa >> FRAC_BITS);
         ang_ff[1] <= 32'(pb >> FRAC_BITS);
      end
   end

   // Two rotation CORDIC lanes for the sines.
   for (genvar l = 0; l < 2; l++) begin : g_lane
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin
         logic signed [33:0] x_prev, y_prev, z_prev, x_in, y_in, z_in, step;
         always_comb begin
            if (i == 0) begin
               x_prev = CORDIC_GAIN_INV;
               y_prev = '0;
               z_prev = $signed({2'b0, ang_ff[l]});
            end else begin
               x_prev = sn_x_ff[l][(i == 0) ? 0 : i-1];
               y_prev = sn_y_ff[l][(i == 0) ? 0 : i-1];
               z_prev = sn_z_ff[l][(i == 0) ? 0 : i-1];
            end
            step = $signed({2'b0, ATAN_TAB[i]});
            if (!z_prev[33]) begin
               x_in = x_prev - (y_prev >>> i);
               y_in = y_prev + (x_prev >>> i);
               z_in = z_prev - step;
            end else begin
               x_in = x_prev + (y_prev >>> i);
               y_in = y_prev - (x_prev >>> i);
               z_in = z_prev + step;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sn_x_ff[l][i] <= x_in;
               sn_y_ff[l][i] <= y_in;
               sn_z_ff[l][i] <= z_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         logic signed [33:0] y_fin;
         if (adv) begin
            y_fin = sn_y_ff[l][CORDIC_STEPS-1];
            if (y_fin[33]) begin
               sv_ff[l] <= '0;
            end else if (y_fin > (34'sd1 <<< WBITS)) begin
               sv_ff[l] <= 31'd1 << WBITS;
            end else begin
               sv_ff[l] <= y_fin[30:0];
            end
         end
      end

      // Restoring divider: sine scaled up by the word size over the half-angle sine.
      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
         logic [30:0] rem_prev, num_prev, rem_in, sd;
         logic [60:0] quo_prev, quo_in;
         logic [31:0] rem2;
         logic dbit;
         always_comb begin
            if (j == 0) begin
               rem_prev = '0;
               quo_prev = '0;
               num_prev = sv_ff[l];
            end else begin
               rem_prev = dv_rem_ff[l][(j == 0) ? 0 : j-1];
               quo_prev = dv_quo_ff[l][(j == 0) ? 0 : j-1];
               num_prev = dv_num_ff[l][(j == 0) ? 0 : j-1];
            end
            sd   = (side_ff[S_SC + j].s == '0) ? 31'd1 : side_ff[S_SC + j].s;
            dbit = (j < 31) ? num_prev[(j < 31) ? 30 - j : 0] : 1'b0;
            rem2 = {rem_prev, dbit};
            if (rem2 >= 32'(sd)) begin
               rem_in = 31'(rem2 - 32'(sd));
               quo_in = {quo_prev[59:0], 1'b1};
            end else begin
               rem_in = rem2[30:0];
               quo_in = {quo_prev[59:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[l][j] <= rem_in;
               dv_quo_ff[l][j] <= quo_in;
               dv_num_ff[l][j] <= num_prev;
            end
         end
      end
   end

   // Weights times components, split into two partial products each, then summed.
   always_ff @(posedge clock) begin
      logic [60:0] wa, wb;
      if (adv) begin
         wa = dv_quo_ff[0][DIV_STEPS-1];
         wb = dv_quo_ff[1][DIV_STEPS-1];
         for (int i = 0; i < 4; i++) begin
            pa_lo_ff[i] <= 49'($signed({1'b0, wa[30:0]}))
                         * 49'($signed(side_ff[S_P-1].ctx.q[i]));
            pa_hi_ff[i] <= 48'($signed({1'b0, wa[60:31]}))
                         * 48'($signed(side_ff[S_P-1].ctx.q[i]));
            pb_lo_ff[i] <= 49'($signed({1'b0, wb[30:0]}))
                         * 49'($signed(side_ff[S_P-1].ctx.r[i]));
            pb_hi_ff[i] <= 48'($signed({1'b0, wb[60:31]}))
                         * 48'($signed(side_ff[S_P-1].ctx.r[i]));
            acc_ff[i] <= 64'(pa_lo_ff[i]) + (64'(pa_hi_ff[i]) <<< 31)
                       + 64'(pb_lo_ff[i]) + (64'(pb_hi_ff[i]) <<< 31);
         end
      end
   end

   // Output register: pick the result of the path that applies.
   always_ff @(posedge clock) begin
      logic signed [63:0] sph;
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            sph = (acc_ff[i] + 64'sd536870912) >>> WBITS;
            if (side_ff[S_Q].ctx.keep) begin
               rsp_out_ff[i] <= sat16(48'($signed(side_ff[S_Q].ctx.q[i])));
            end else if (side_ff[S_Q].lin_sel) begin
               rsp_out_ff[i] <= side_ff[S_Q].lin[i];
            end else begin
               rsp_out_ff[i] <= sat16(48'(sph));
            end
         end
         if (side_ff[S_Q].ctx.keep) begin
            rsp_path_ff <= PATH_KEEP;
         end else if (side_ff[S_Q].lin_sel) begin
            rsp_path_ff <= PATH_LINEAR;
         end else begin
            rsp_path_ff <= PATH_SLERP;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_w = rsp_out_ff[0];
   assign rsp_out_x = rsp_out_ff[1];
   assign rsp_out_y = rsp_out_ff[2];
   assign rsp_out_z = rsp_out_ff[3];
   assign rsp_path  = rsp_path_ff;

endmodule

@@ hdl/quaternion_slerp_core.sv @@
// Fixed-point quaternion slerp, Q2.14 in and out.
// Request channel (req_valid/req_ready) carries quaternions q and r and the
// blend factor; the response channel (rsp_valid/rsp_ready) returns one
// saturated quaternion and a path code per request, in request order.
// The threshold register is written through csr_we/csr_wdata.
// Throughput is one item per cycle while the receiver does not stall. A
// request passes two front stages for the dot product, then the queue, then
// a back end of 161 stages set by the 31-stage square root, two 30-stage
// CORDIC units and the 61-stage dividers, plus the output register.
// When the receiver stalls, the whole back end holds; the queue keeps taking
// requests until queued and front items fill its depth, then req_ready drops.
// Reset empties the pipeline and the queue and sets the threshold to 16.
module quaternion_slerp_core #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_q_w,
   input  logic signed [15:0] req_q_x,
   input  logic signed [15:0] req_q_y,
   input  logic signed [15:0] req_q_z,
   input  logic signed [15:0] req_r_w,
   input  logic signed [15:0] req_r_x,
   input  logic signed [15:0] req_r_y,
   input  logic signed [15:0] req_r_z,
   input  logic [14:0] req_blend,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_out_w,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic [1:0] rsp_path,
   input  logic csr_we,
   input  logic [14:0] csr_wdata
);
   import qs_pkg::*;

   logic [14:0] thr_ff;
   logic push_valid, pop, head_valid;
   ctx_type push_ctx, head_ctx;
   logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   qs_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_q_w(req_q_w), .req_q_x(req_q_x), .req_q_y(req_q_y), .req_q_z(req_q_z),
      .req_r_w(req_r_w), .req_r_x(req_r_x), .req_r_y(req_r_y), .req_r_z(req_r_z),
      .req_blend(req_blend),
      .fifo_count(fifo_count),
      .push_valid(push_valid), .push_ctx(push_ctx)
   );

   qs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ctx(push_ctx),
      .pop(pop), .head_valid(head_valid), .head_ctx(head_ctx),
      .count(fifo_count)
   );

   qs_back u_back (
      .clock(clock), .reset(reset),
      .thr(thr_ff),
      .head_valid(head_valid), .head_ctx(head_ctx), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_w(rsp_out_w), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_path(rsp_path)
   );

endmodule

@@ hdl/qs_checker.sv @@
module qs_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] rsp_out_w,
   input logic signed [15:0] rsp_out_x,
   input logic signed [15:0] rsp_out_y,
   input logic signed [15:0] rsp_out_z,
   input logic [1:0] rsp_path
);

   // Reset empties the pipeline: no response the cycle after.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // With the front and queue empty after reset, requests are taken at once.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request channel not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_w) && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_path))
      else $error("response payload changed while stalled");

endmodule

bind quaternion_slerp_core qs_checker u_qs_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_w(rsp_out_w), .rsp_out_x(rsp_out_x),
   .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
   .rsp_path(rsp_path)
);
